// ===== design/ffha_pkg.sv =====
// Shared types and constants for the first-fit heap allocator.
// No dependencies; compiled before first_fit_heap_allocator_top.
package ffha_pkg;

    // Stream payload widths
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 1;

    // Field widths
    localparam int BYTES_W = 16;

    // Request kinds carried on s_tuser
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A_INIT,
        ST_A_START,
        ST_A_WALK,
        ST_A_WRB,
        ST_A_LINK,
        ST_A_WRP,
        ST_F_START,
        ST_F_WALK,
        ST_F_RDB,
        ST_F_RDN,
        ST_F_MERGE,
        ST_F_WRP,
        ST_DONE
    } state_t;

endpackage

// ===== design/first_fit_heap_allocator_top.sv =====
// First-fit heap allocator with address-ordered free list and coalescing.
// Depends on ffha_pkg (types, widths, request kinds).
//
// Channel | Direction | Handshake          | Payload
// --------+-----------+--------------------+------------------------------------------
// s_      | in        | s_tvalid/s_tready  | tdata: request_bytes, release_offset; tuser: opcode
// m_      | out       | m_tvalid/m_tready  | tdata: block_offset; tuser: success
//
// One request at a time. Allocate: accept, fetch the head (after making the arena one free
// block on the first allocate), read one header per free-list block visited (one header read
// per cycle), split and relink, load the result. Free: accept, start, walk the free blocks
// below the freed one, read, insert and merge, load. A null or malformed free skips to load.
// Reset (aresetn low, synchronous) empties the list; header memory needs no clearing pass.
// A waiting result holds in the output register; the next request is taken meanwhile.
module first_fit_heap_allocator_top #(
    parameter int HEAP_BYTES   = 512,
    parameter int HEADER_BYTES = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] request_bytes, [31:16] release_offset
    input  logic [ffha_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] opcode
    input  logic [ffha_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] block_offset
    output logic [ffha_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] success
    output logic [ffha_pkg::M_TUSER_W-1:0] m_tuser
);
    import ffha_pkg::*;

    localparam int WORDS    = HEAP_BYTES / 4;
    localparam int HDR_SPAN = ((HEADER_BYTES + 3) / 4) * 4;
    localparam int WI       = $clog2(WORDS + 1);
    localparam int AW       = $clog2(WORDS);

    localparam logic [WI-1:0]      NIL       = WI'(WORDS);
    localparam logic [16:0]        HDR17     = 17'(HDR_SPAN);
    localparam logic [17:0]        HDR18     = 18'(HDR_SPAN);
    localparam logic [16:0]        MIN_NEED  = 17'(HDR_SPAN + 4);
    localparam logic [17:0]        SPLIT_ADD = 18'(HDR_SPAN + 4);
    localparam logic [BYTES_W-1:0] INIT_SIZE = BYTES_W'(WORDS * 4 - HDR_SPAN);
    localparam logic [14:0]        WORDS15   = 15'(WORDS);
    localparam logic [16:0]        WORDS17   = 17'(WORDS);

    // Clamp a stored link to a valid index or null
    function automatic logic [WI-1:0] link_clamp(input logic [WI-1:0] v);
        return (v >= NIL) ? NIL : v;
    endfunction

    // Header memories: payload size and next-free link per arena word
    logic [BYTES_W-1:0] size_mem [WORDS];
    logic [WI-1:0]      link_mem [WORDS];

    logic               mem_we;
    logic               mem_re;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic [BYTES_W-1:0] wr_size;
    logic [WI-1:0]      wr_link;
    logic [BYTES_W-1:0] rd_size_reg;
    logic [WI-1:0]      rd_link_reg;

    // Control and working registers
    state_t             state_reg, state_next;
    logic               started_reg, started_next;
    logic [WI-1:0]      head_reg, head_next;
    logic [WI-1:0]      cur_reg, cur_next;
    logic [WI-1:0]      prev_reg, prev_next;
    logic [WI-1:0]      blk_reg, blk_next;
    logic [WI-1:0]      steps_reg, steps_next;
    logic [WI-1:0]      nxt_reg, nxt_next;
    logic [WI-1:0]      blink_reg, blink_next;
    logic [16:0]        need_reg, need_next;
    logic               split_reg, split_next;
    logic [BYTES_W-1:0] psize_reg, psize_next;
    logic [BYTES_W-1:0] bsize_reg, bsize_next;
    logic [BYTES_W-1:0] nbsize_reg, nbsize_next;
    logic [WI-1:0]      nblink_reg, nblink_next;
    logic [BYTES_W-1:0] res_off_reg, res_off_next;
    logic               res_ok_reg, res_ok_next;
    logic               m_valid_reg, m_valid_next;
    logic [BYTES_W-1:0] m_off_reg, m_off_next;
    logic               m_ok_reg, m_ok_next;

    // Request decode
    logic               s_fire;
    logic [BYTES_W-1:0] s_req;
    logic [BYTES_W-1:0] s_off;
    logic [16:0]        need_rnd;
    logic [16:0]        need_c;
    logic [16:0]        off_diff;
    logic               fr_null;
    logic               fr_bad;
    logic [WI-1:0]      fr_idx;

    // Walk and merge datapath
    logic [WI-1:0]      rd_link_c;
    logic [WI-1:0]      steps_inc;
    logic               fit;
    logic               split;
    logic [16:0]        r_idx;
    logic               do_split;
    logic [BYTES_W-1:0] rsize;
    logic               a_more;
    logic               f_more;
    logic               f_start_go;
    logic               fwd;
    logic               bwd;
    logic               out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign s_req    = s_tdata[15:0];
    assign s_off    = s_tdata[31:16];

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_off_reg;
    assign m_tuser  = m_ok_reg;
    assign out_free = !m_valid_reg || m_tready;

    // Round the allocate size up to a word, with a floor of header plus one word
    assign need_rnd = (17'(s_req) + 17'd3) & ~17'd3;
    assign need_c   = (need_rnd < MIN_NEED) ? MIN_NEED : need_rnd;

    // Validate the free offset
    assign off_diff = 17'(s_off) - HDR17;
    assign fr_null  = (s_off == '0);
    assign fr_bad   = !started_reg || (17'(s_off) < HDR17) || (s_off[1:0] != 2'b00) ||
                      (off_diff[16:2] >= WORDS15);
    assign fr_idx   = WI'(off_diff[16:2]);

    // Examine the header just read
    assign rd_link_c  = link_clamp(rd_link_reg);
    assign steps_inc  = WI'(steps_reg + 1'b1);
    assign fit        = (17'(rd_size_reg) >= need_reg);
    assign split      = (18'(rd_size_reg) >= (18'(need_reg) + SPLIT_ADD));
    assign r_idx      = 17'(cur_reg) + 17'((17'(need_reg) + HDR17) >> 2);
    assign do_split   = split && (r_idx < WORDS17);
    assign rsize      = BYTES_W'(17'(rd_size_reg) - need_reg - HDR17);
    assign a_more     = (rd_link_c != NIL) && (steps_inc < NIL);
    assign f_more     = (rd_link_c != NIL) && (rd_link_c < blk_reg) && (steps_inc < NIL);
    assign f_start_go = (head_reg != NIL) && (head_reg < blk_reg);

    // Merge tests: block end touches the next block, previous block end touches this one
    assign fwd = (cur_reg != NIL) &&
                 ((18'({blk_reg, 2'b00}) + HDR18 + 18'(bsize_reg)) == 18'({cur_reg, 2'b00}));
    assign bwd = ((18'({prev_reg, 2'b00}) + HDR18 + 18'(psize_reg)) ==
                  18'({blk_reg, 2'b00}));

    // Header memories with registered read outputs
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            size_mem[wr_addr] <= wr_size;
            link_mem[wr_addr] <= wr_link;
        end
        if (mem_re) begin
            rd_size_reg <= size_mem[rd_addr];
            rd_link_reg <= link_mem[rd_addr];
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_tuser[0] == OP_ALLOC) begin
                        state_next = started_reg ? ST_A_START : ST_A_INIT;
                    end else if (fr_null || fr_bad) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_F_START;
                    end
                end
            end
            ST_A_INIT:  state_next = ST_A_START;
            ST_A_START: state_next = (head_reg != NIL) ? ST_A_WALK : ST_DONE;
            ST_A_WALK: begin
                if (fit) begin
                    state_next = ST_A_WRB;
                end else if (!a_more) begin
                    state_next = ST_DONE;
                end
            end
            ST_A_WRB:   state_next = ST_A_LINK;
            ST_A_LINK:  state_next = (prev_reg == NIL) ? ST_DONE : ST_A_WRP;
            ST_A_WRP:   state_next = ST_DONE;
            ST_F_START: state_next = f_start_go ? ST_F_WALK : ST_F_RDB;
            ST_F_WALK:  state_next = f_more ? ST_F_WALK : ST_F_RDB;
            ST_F_RDB:   state_next = ST_F_RDN;
            ST_F_RDN:   state_next = ST_F_MERGE;
            ST_F_MERGE: state_next = ST_F_WRP;
            ST_F_WRP:   state_next = ST_DONE;
            ST_DONE:    state_next = out_free ? ST_IDLE : ST_DONE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory control and result register
    always_comb begin
        started_next = started_reg;
        head_next    = head_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        blk_next     = blk_reg;
        steps_next   = steps_reg;
        nxt_next     = nxt_reg;
        blink_next   = blink_reg;
        need_next    = need_reg;
        split_next   = split_reg;
        psize_next   = psize_reg;
        bsize_next   = bsize_reg;
        nbsize_next  = nbsize_reg;
        nblink_next  = nblink_reg;
        res_off_next = res_off_reg;
        res_ok_next  = res_ok_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_off_next   = m_off_reg;
        m_ok_next    = m_ok_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        wr_addr      = '0;
        rd_addr      = '0;
        wr_size      = '0;
        wr_link      = '0;

        case (state_reg)
            // Take a request and settle the trivial answers
            ST_IDLE: begin
                if (s_fire) begin
                    need_next    = need_c;
                    prev_next    = NIL;
                    cur_next     = head_reg;
                    steps_next   = '0;
                    blk_next     = fr_idx;
                    res_off_next = '0;
                    res_ok_next  = (s_tuser[0] == OP_FREE) && fr_null;
                end
            end
            // Make the whole arena one free block
            ST_A_INIT: begin
                mem_we       = 1'b1;
                wr_addr      = '0;
                wr_size      = INIT_SIZE;
                wr_link      = NIL;
                started_next = 1'b1;
                head_next    = '0;
            end
            // Fetch the list head
            ST_A_START: begin
                cur_next = head_reg;
                if (head_reg != NIL) begin
                    mem_re  = 1'b1;
                    rd_addr = head_reg[AW-1:0];
                end
            end
            // First fit: split off the tail or advance to the next free block
            ST_A_WALK: begin
                if (fit) begin
                    blk_next     = cur_reg;
                    blink_next   = rd_link_reg;
                    split_next   = do_split;
                    nxt_next     = do_split ? r_idx[WI-1:0] : rd_link_c;
                    res_off_next = BYTES_W'(17'({cur_reg, 2'b00}) + HDR17);
                    res_ok_next  = 1'b1;
                    if (do_split) begin
                        mem_we  = 1'b1;
                        wr_addr = r_idx[AW-1:0];
                        wr_size = rsize;
                        wr_link = rd_link_c;
                    end
                end else begin
                    prev_next  = cur_reg;
                    cur_next   = rd_link_c;
                    steps_next = steps_inc;
                    if (a_more) begin
                        mem_re  = 1'b1;
                        rd_addr = rd_link_c[AW-1:0];
                    end
                end
            end
            // Shrink the allocated block when split
            ST_A_WRB: begin
                if (split_reg) begin
                    mem_we  = 1'b1;
                    wr_addr = blk_reg[AW-1:0];
                    wr_size = need_reg[BYTES_W-1:0];
                    wr_link = blink_reg;
                end
            end
            // Unlink: move the head or read the previous header
            ST_A_LINK: begin
                if (prev_reg == NIL) begin
                    head_next = nxt_reg;
                end else begin
                    mem_re  = 1'b1;
                    rd_addr = prev_reg[AW-1:0];
                end
            end
            ST_A_WRP: begin
                mem_we  = 1'b1;
                wr_addr = prev_reg[AW-1:0];
                wr_size = rd_size_reg;
                wr_link = nxt_reg;
            end
            // Find the insertion point in address order
            ST_F_START: begin
                if (f_start_go) begin
                    mem_re  = 1'b1;
                    rd_addr = head_reg[AW-1:0];
                end
            end
            ST_F_WALK: begin
                prev_next  = cur_reg;
                psize_next = rd_size_reg;
                cur_next   = rd_link_c;
                steps_next = steps_inc;
                if (f_more) begin
                    mem_re  = 1'b1;
                    rd_addr = rd_link_c[AW-1:0];
                end
            end
            ST_F_RDB: begin
                mem_re  = 1'b1;
                rd_addr = blk_reg[AW-1:0];
            end
            ST_F_RDN: begin
                bsize_next = rd_size_reg;
                if (cur_reg != NIL) begin
                    mem_re  = 1'b1;
                    rd_addr = cur_reg[AW-1:0];
                end
            end
            // Link the block to its successor, absorbing the successor if adjacent
            ST_F_MERGE: begin
                nbsize_next = fwd ? BYTES_W'(17'(bsize_reg) + HDR17 + 17'(rd_size_reg))
                                  : bsize_reg;
                nblink_next = fwd ? rd_link_c : cur_reg;
                mem_we      = 1'b1;
                wr_addr     = blk_reg[AW-1:0];
                wr_size     = nbsize_next;
                wr_link     = nblink_next;
            end
            // Link the predecessor to the block, absorbing the block if adjacent
            ST_F_WRP: begin
                res_off_next = '0;
                res_ok_next  = 1'b1;
                if (prev_reg == NIL) begin
                    head_next = blk_reg;
                end else begin
                    mem_we  = 1'b1;
                    wr_addr = prev_reg[AW-1:0];
                    wr_size = bwd ? BYTES_W'(17'(psize_reg) + HDR17 + 17'(nbsize_reg))
                                  : psize_reg;
                    wr_link = bwd ? link_clamp(nblink_reg) : blk_reg;
                end
            end
            // Hand the result to the output register once it is free
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_off_next   = res_off_reg;
                    m_ok_next    = res_ok_reg;
                end
            end
            default: begin
                m_valid_next = m_valid_reg && !m_tready;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
            head_reg    <= NIL;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            started_reg <= started_next;
            head_reg    <= head_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge aclk) begin
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        blk_reg     <= blk_next;
        steps_reg   <= steps_next;
        nxt_reg     <= nxt_next;
        blink_reg   <= blink_next;
        need_reg    <= need_next;
        split_reg   <= split_next;
        psize_reg   <= psize_next;
        bsize_reg   <= bsize_next;
        nbsize_reg  <= nbsize_next;
        nblink_reg  <= nblink_next;
        res_off_reg <= res_off_next;
        res_ok_reg  <= res_ok_next;
        m_off_reg   <= m_off_next;
        m_ok_reg    <= m_ok_next;
    end

endmodule
